>>> sv/o3d_pkg.sv
// Package for the exact orientation unit: widths, types, minor index tables
// and the shared multiply and sign helpers. Depends on nothing.
`default_nettype none
package o3d_pkg;
  localparam int GRID_BITS = 24;
  localparam longint CLAMP_LIM = 64'sd1 << GRID_BITS;
  localparam int CW = 26;
  localparam int DW = 27;
  localparam int SQW = 50;
  localparam int PW = 54;
  localparam int MW = 53;
  localparam int RW = 51;
  localparam int FW = 106;
  localparam int NPT = 12;
  localparam int NMIN = 9;
  localparam int NTERM = 12;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [1:0] sgn_t;

  typedef struct packed {
    logic [NMIN-1:0][MW-1:0] minor;
    logic [2:0][RW-1:0] r;
    logic [2:0][DW-1:0] cfi;
  } front_out_t;

  localparam int MI_A [NMIN] = '{3, 0, 0, 3, 0, 0, 4, 1, 1};
  localparam int MI_B [NMIN] = '{7, 7, 4, 8, 8, 5, 8, 8, 5};
  localparam int MI_C [NMIN] = '{4, 1, 1, 5, 2, 2, 5, 2, 2};
  localparam int MI_D [NMIN] = '{6, 6, 3, 6, 6, 3, 7, 7, 4};

  function automatic logic signed [PW-1:0] mul27(logic signed [26:0] a,
                                                 logic signed [26:0] b);
    logic signed [PW-1:0] p;
    p = a * b;
    return p;
  endfunction

  function automatic logic signed [FW-1:0] ext_pp(logic signed [PW-1:0] p);
    return $signed({{(FW-PW){p[PW-1]}}, p});
  endfunction

  function automatic sgn_t sign_of(logic signed [FW-1:0] v);
    sgn_t s;
    if (v[FW-1]) s = 2'sb11;
    else if (v != '0) s = 2'sb01;
    else s = 2'sb00;
    return s;
  endfunction
endpackage
`default_nettype wire

>>> sv/o3d_front.sv
// Front pipeline: clamp, edge vectors, squares, 2x2 minor products and the
// minors with the squared-norm differences. Three register stages. Uses o3d_pkg.
`default_nettype none
module o3d_front import o3d_pkg::*; (
  input  wire logic       clk,
  input  wire logic       en,
  input  wire coord_t     pts [NPT],
  output front_out_t      fout
);
  logic signed [DW-1:0]  d_r [9];
  logic signed [SQW-1:0] sq_r [NPT];
  logic signed [PW-1:0]  prod_r [2*NMIN];
  logic signed [RW-1:0]  r_b_r [3];
  logic signed [DW-1:0]  cfi_b_r [3];
  front_out_t            fout_r;

  logic signed [CW-1:0]  p_c [NPT];
  logic signed [DW-1:0]  d_nxt [9];
  logic signed [SQW-1:0] sq_nxt [NPT];
  logic signed [PW-1:0]  prod_nxt [2*NMIN];
  logic signed [RW-1:0]  r_nxt [3];
  logic signed [RW:0]    ra_c;
  logic signed [RW:0]    rs_c;
  logic signed [2*CW-1:0] sqf_c;
  logic signed [PW-1:0]  mdiff_c;
  front_out_t            fout_nxt;

  always_comb begin
    for (int k = 0; k < NPT; k++) begin
      if (longint'(pts[k]) > CLAMP_LIM || longint'(pts[k]) < -CLAMP_LIM) p_c[k] = '0;
      else p_c[k] = pts[k];
    end
    for (int k = 0; k < 9; k++) begin
      d_nxt[k] = DW'(p_c[3 + k]) - DW'(p_c[k % 3]);
    end
    for (int k = 0; k < NPT; k++) begin
      sqf_c = p_c[k] * p_c[k];
      sq_nxt[k] = sqf_c[SQW-1:0];
    end
  end

  always_comb begin
    ra_c = (RW+1)'(sq_r[0]) + (RW+1)'(sq_r[1]) + (RW+1)'(sq_r[2]);
    for (int j = 0; j < 3; j++) begin
      rs_c = (RW+1)'(sq_r[3+3*j]) + (RW+1)'(sq_r[4+3*j]) + (RW+1)'(sq_r[5+3*j]) - ra_c;
      r_nxt[j] = rs_c[RW-1:0];
    end
    for (int k = 0; k < NMIN; k++) begin
      prod_nxt[2*k]   = mul27(d_r[MI_A[k]], d_r[MI_B[k]]);
      prod_nxt[2*k+1] = mul27(d_r[MI_C[k]], d_r[MI_D[k]]);
    end
  end

  always_comb begin
    fout_nxt = fout_r;
    for (int k = 0; k < NMIN; k++) begin
      mdiff_c = prod_r[2*k] - prod_r[2*k+1];
      fout_nxt.minor[k] = mdiff_c[MW-1:0];
    end
    for (int j = 0; j < 3; j++) begin
      fout_nxt.r[j] = r_b_r[j];
      fout_nxt.cfi[j] = cfi_b_r[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
      sq_r <= sq_nxt;
      prod_r <= prod_nxt;
      r_b_r <= r_nxt;
      cfi_b_r[0] <= d_r[2];
      cfi_b_r[1] <= d_r[5];
      cfi_b_r[2] <= d_r[8];
      fout_r <= fout_nxt;
    end
  end

  assign fout = fout_r;
endmodule
`default_nettype wire

>>> sv/o3d_back.sv
// Back pipeline: split wide operands into 27-bit halves, multiply them
// pairwise, combine, take signs of the four cofactor sums. Uses o3d_pkg.
`default_nettype none
module o3d_back import o3d_pkg::*; (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire front_out_t  fin,
  output sgn_t             sgn [4]
);
  logic signed [PW-1:0] pp_r [NTERM][4];
  logic signed [FW-1:0] full_r [NTERM];
  sgn_t                 sgn_r [4];

  logic signed [PW-1:0] pp_nxt [NTERM][4];
  logic signed [FW-1:0] full_nxt [NTERM];
  sgn_t                 sgn_nxt [4];
  logic signed [RW-1:0] x_c;
  logic signed [MW-1:0] m_c;
  logic signed [26:0]   xh_c, xl_c, mh_c, ml_c;
  logic signed [FW-1:0] sum_c;

  always_comb begin
    for (int t = 0; t < NTERM; t++) begin
      if (t < 3) begin
        x_c = RW'($signed(fin.cfi[t]));
        m_c = $signed(fin.minor[t]);
      end else begin
        x_c = $signed(fin.r[t % 3]);
        m_c = $signed(fin.minor[t - 3]);
      end
      xh_c = $signed({x_c[RW-1], x_c[RW-1:25]});
      xl_c = $signed({2'b00, x_c[24:0]});
      mh_c = $signed(m_c[MW-1:26]);
      ml_c = $signed({1'b0, m_c[25:0]});
      pp_nxt[t][0] = mul27(xh_c, mh_c);
      pp_nxt[t][1] = mul27(xh_c, ml_c);
      pp_nxt[t][2] = mul27(xl_c, mh_c);
      pp_nxt[t][3] = mul27(xl_c, ml_c);
    end
  end

  always_comb begin
    for (int t = 0; t < NTERM; t++) begin
      full_nxt[t] = (ext_pp(pp_r[t][0]) <<< 51) + (ext_pp(pp_r[t][1]) <<< 25)
                  + (ext_pp(pp_r[t][2]) <<< 26) + ext_pp(pp_r[t][3]);
    end
    for (int g = 0; g < 4; g++) begin
      sum_c = full_r[3*g] - full_r[3*g+1] + full_r[3*g+2];
      sgn_nxt[g] = sign_of(sum_c);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pp_r <= pp_nxt;
      full_r <= full_nxt;
      sgn_r <= sgn_nxt;
    end
  end

  assign sgn = sgn_r;
endmodule
`default_nettype wire

>>> sv/orient3d_exact_perturbed_unit.sv
// Throughput: one word per cycle; the whole pipeline advances in lockstep and
// holds only while a valid result word is stalled at the output.
// Reset clears the valid bits and the perturbation enable; data registers
// are not reset. Uses o3d_pkg, o3d_front and o3d_back.
`default_nettype none
module orient3d_exact_perturbed_unit import o3d_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire coord_t       in_a_x,
  input  wire coord_t       in_a_y,
  input  wire coord_t       in_a_z,
  input  wire coord_t       in_b_x,
  input  wire coord_t       in_b_y,
  input  wire coord_t       in_b_z,
  input  wire coord_t       in_c_x,
  input  wire coord_t       in_c_y,
  input  wire coord_t       in_c_z,
  input  wire coord_t       in_d_x,
  input  wire coord_t       in_d_y,
  input  wire coord_t       in_d_z,
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic signed [1:0] out_orientation,
  output logic [1:0]        out_decided_by,
  input  wire logic         cfg_we,
  input  wire logic         cfg_wdata
);
  localparam int DEPTH = 7;

  logic [DEPTH-1:0] vld_r;
  logic [DEPTH-1:0] vld_nxt;
  logic             perturb_en_r;
  logic signed [1:0] orient_r, orient_nxt;
  logic [1:0]       by_r, by_nxt;
  logic             en;
  coord_t           pts [NPT];
  front_out_t       fout;
  sgn_t             sgn [4];

  assign en = !(vld_r[DEPTH-1] && out_stall);
  assign in_stall = !en;
  assign vld_nxt = {vld_r[DEPTH-2:0], in_valid};

  assign pts = '{in_a_x, in_a_y, in_a_z, in_b_x, in_b_y, in_b_z,
                 in_c_x, in_c_y, in_c_z, in_d_x, in_d_y, in_d_z};

  o3d_front u_front (.clk(clk), .en(en), .pts(pts), .fout(fout));
  o3d_back  u_back  (.clk(clk), .en(en), .fin(fout), .sgn(sgn));

  always_comb begin
    if (sgn[0] != 2'sb00 || !perturb_en_r) begin
      orient_nxt = sgn[0];
      by_nxt = 2'd0;
    end else if (sgn[1] != 2'sb00) begin
      orient_nxt = sgn[1];
      by_nxt = 2'd1;
    end else if (sgn[2] != 2'sb00) begin
      orient_nxt = -sgn[2];
      by_nxt = 2'd2;
    end else begin
      orient_nxt = sgn[3];
      by_nxt = 2'd3;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      perturb_en_r <= 1'b0;
    end else begin
      if (en) vld_r <= vld_nxt;
      if (cfg_we) perturb_en_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      orient_r <= orient_nxt;
      by_r <= by_nxt;
    end
  end

  assign out_valid = vld_r[DEPTH-1];
  assign out_orientation = orient_r;
  assign out_decided_by = by_r;

  a_no_bad_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_orientation != 2'sb10)
    else $error("orientation code out of range");

  a_pert_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_decided_by == 2'd1 || out_decided_by == 2'd2))
      |-> out_orientation != 2'sb00)
    else $error("perturbation term decided with a zero sign");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid after reset");
endmodule
`default_nettype wire
